FILE: rtl/core/bf3_pkg.sv
// Shared types and constants for the 3x3 box filter.
// No dependencies; imported by bf3_window, bf3_out_queue and the top level.
`default_nettype none

package bf3_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned IW_RESET  = 640;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;

  // floor(s / 9) == (s * 7282) >> 16 for every s below 2296
  localparam logic [12:0] DIV9_RECIP = 13'd7282;
  localparam int unsigned DIV9_SHIFT = 16;

  localparam logic [1:0] ROW_FULL = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } s1_ctrl_t;

  typedef struct packed {
    logic valid;
    logic last;
    sum_t sum;
  } s2_t;

  typedef struct packed {
    pix_t filtered;
    logic row_end;
  } res_t;

  function automatic pix_t div9(sum_t s);
    logic [24:0] p;
    p = 25'(s) * 25'(DIV9_RECIP);
    return p[DIV9_SHIFT +: PIX_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bf3_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bf3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1026
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/bf3_window.sv
// 3x3 window columns and nine-pixel sum, registered into the sum stage.
// Depends on bf3_pkg.
`default_nettype none

module bf3_window import bf3_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire s1_ctrl_t s1_i,
  input  wire pix_t     top_i,
  input  wire pix_t     mid_i,
  input  wire pix_t     bot_i,
  output s2_t           s2_o
);

  // [0..2] column c-2 top..bottom, [3..5] column c-1
  pix_t win_q [6];
  sum_t sum_d;
  s2_t  s2_q;

  always_comb begin
    sum_d = sum_t'(win_q[0]) + sum_t'(win_q[1]) + sum_t'(win_q[2])
          + sum_t'(win_q[3]) + sum_t'(win_q[4]) + sum_t'(win_q[5])
          + sum_t'(top_i) + sum_t'(mid_i) + sum_t'(bot_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_i.valid) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_i;
      win_q[4] <= mid_i;
      win_q[5] <= bot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q.valid <= s1_i.valid && s1_i.emit;
      if (s1_i.valid) begin
        s2_q.last <= s1_i.last;
        s2_q.sum  <= sum_d;
      end
    end
  end

  assign s2_o = s2_q;

endmodule

`default_nettype wire

FILE: rtl/core/bf3_out_queue.sv
// Divide-by-nine and a four-entry result queue towards the output channel.
// Depends on bf3_pkg.
`default_nettype none

module bf3_out_queue import bf3_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire s2_t               s2_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output res_t                   res_o,
  output logic      [QCNT_W-1:0] level_o
);

  res_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;
  res_t              push_data;

  assign push = s2_i.valid;
  assign pop  = out_valid_o && out_ready_i;

  assign push_data.filtered = div9(s2_i.sum);
  assign push_data.row_end  = s2_i.last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign res_o       = entry_q[rd_ptr_q];
  assign level_o     = cnt_q;

endmodule

`default_nettype wire

FILE: rtl/core/box_filter_3x3_stream_top.sv
// Top level of the streaming 3x3 box filter: column/row control, line store,
// forwarding. Depends on bf3_pkg, bf3_ram, bf3_window and bf3_out_queue.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------
//   input   | in_valid_i / in_ready_o   | pixel_i, frame_start_i
//   output  | out_valid_o / out_ready_i | filtered_o, row_end_o
//   config  | cfg_we_i                  | cfg_wdata_i (interior width)
//
// One item per cycle sustained while in_ready_o is high. Each accepted item goes
// through line-store read, window sum, then the divide into the result queue.
// Both line rows share one RAM word; its single read port sets the rate.
// Reset clears counters and window; line-store contents stay undefined.
// in_ready_o drops only when the four-entry result queue plus items in
// flight would overflow, so an output stall back-pressures after a few items.
`default_nettype none

module box_filter_3x3_stream_top import bf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire logic             frame_start_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [PIX_W-1:0] filtered_o,
  output logic                  row_end_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned StoreDepth = MAX_WIDTH + 2;
  localparam int unsigned AW         = $clog2(StoreDepth);
  localparam int unsigned ResetIw    = (IW_RESET > MAX_WIDTH) ? MAX_WIDTH : IW_RESET;
  localparam logic [AW-1:0] ResetLast = AW'(ResetIw + 1);
  localparam logic [AW-1:0] MaxLast   = AW'(MAX_WIDTH + 1);

  logic [AW-1:0] last_col_q, last_col_d;
  logic [AW-1:0] col_q, col_d, c_cur;
  logic [1:0]    row_q, row_d, row_cur;
  logic          accept, is_last, is_emit;

  s1_ctrl_t      s1_q;
  logic [AW-1:0] s1_addr_q;
  pix_t          s1_bot_q;
  logic          fwd_q;
  logic [2*PIX_W-1:0] fwd_data_q;
  logic [2*PIX_W-1:0] rdata;
  pix_t          s1_top, s1_mid;

  s2_t               s2;
  res_t              res;
  logic [QCNT_W-1:0] level;
  logic [QCNT_W-1:0] inflight;

  // interior width clamped to 1..MAX_WIDTH, kept as the last bordered column
  always_comb begin
    if (cfg_wdata_i == '0) begin
      last_col_d = AW'(2);
    end else if (int'(cfg_wdata_i) > int'(MAX_WIDTH)) begin
      last_col_d = MaxLast;
    end else begin
      last_col_d = AW'(int'(cfg_wdata_i) + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= ResetLast;
    end else if (cfg_we_i) begin
      last_col_q <= last_col_d;
    end
  end

  assign inflight   = level + QCNT_W'(s1_q.valid) + QCNT_W'(s2.valid);
  assign in_ready_o = (inflight <= QCNT_W'(QDEPTH - 1));
  assign accept     = in_valid_i && in_ready_o;

  assign c_cur   = frame_start_i ? '0 : col_q;
  assign row_cur = frame_start_i ? '0 : row_q;
  assign is_last = (c_cur >= last_col_q);
  assign is_emit = (c_cur >= AW'(2)) && (row_cur == ROW_FULL);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (is_last) begin
        col_d = '0;
        row_d = (row_cur == ROW_FULL) ? row_cur : row_cur + 2'd1;
      end else begin
        col_d = c_cur + AW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_q       <= '0;
      fwd_q      <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_q.valid <= accept;
      if (accept) begin
        s1_q.emit <= is_emit;
        s1_q.last <= is_last;
      end
      // entry written this edge by the item ahead: RAM returns stale data
      fwd_q      <= accept && s1_q.valid && (s1_addr_q == c_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q  <= c_cur;
      s1_bot_q   <= pixel_i;
      fwd_data_q <= {s1_mid, s1_bot_q};
    end
  end

  bf3_ram #(
    .Width (2 * PIX_W),
    .Depth (StoreDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_q.valid),
    .waddr_i (s1_addr_q),
    .wdata_i ({s1_mid, s1_bot_q}),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (rdata)
  );

  assign s1_top = fwd_q ? fwd_data_q[2*PIX_W-1:PIX_W] : rdata[2*PIX_W-1:PIX_W];
  assign s1_mid = fwd_q ? fwd_data_q[PIX_W-1:0]       : rdata[PIX_W-1:0];

  bf3_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1_q),
    .top_i  (s1_top),
    .mid_i  (s1_mid),
    .bot_i  (s1_bot_q),
    .s2_o   (s2)
  );

  bf3_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_i        (s2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .level_o     (level)
  );

  assign filtered_o = res.filtered;
  assign row_end_o  = res.row_end;

endmodule

`default_nettype wire
